[hdl/sllam_pkg.sv]
// ----------------------------------------------------------------------------
// sllam_pkg
// Shared types and helpers for the stacked linear layers block.
// ----------------------------------------------------------------------------
package sllam_pkg;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WEIGHT,
    OP_LOAD,
    OP_LOAD_RUN,
    OP_RUN
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  localparam int unsigned DataW = 32;
  localparam int unsigned AccW  = 64;
  localparam int unsigned CfgW  = 3;
  localparam int unsigned IdxW  = 4;

  function automatic logic [DataW-1:0] sat_q16(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0]  full;
    logic signed [AccW-17:0] sh;
    full = a >>> 16;
    sh   = full[AccW-17:0];
    if (sh > 48'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (sh < -48'sd2147483648) begin
      return 32'h8000_0000;
    end
    return sh[DataW-1:0];
  endfunction

endpackage

[hdl/stacked_linear_layers_argmax_top.sv]
// ----------------------------------------------------------------------------
// stacked_linear_layers_argmax_top
// Chain of fixed-point matrix-vector layers with argmax on the result.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall) either write one weight (func = 0) or load
// one element of the input vector (func = 1). A load beat with last set starts
// a run through the first active_layers (at most LAYERS) weight matrices.
// Beats go into a two-entry queue; the front accepts while the queue has room.
// A weight write or plain load is done in the execution unit as it is popped.
// A run uses one shared multiplier: each layer issues NODES*NODES products and
// then drains the pipeline; then NODES result beats follow, one per cycle while
// the receiver does not stall. Run time per vector is set by the single
// multiply-accumulate path and the one weight RAM port.
// Result beats (out_valid/out_stall) carry out_index and out_value; the last
// beat of a run has end_of_vector set and best_index holding the argmax.
// When the receiver stalls, the held beat stays and the run pauses; queued
// input beats stall once the queue is full.
// Reset empties the queue and the pipeline and sets active_layers to 4.
// Weights and input elements are undefined until written.
// ----------------------------------------------------------------------------
module stacked_linear_layers_argmax_top #(
  parameter int unsigned NODES  = 16,
  parameter int unsigned LAYERS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [1:0]         layer_index,
  input  logic [3:0]         from_node,
  input  logic [3:0]         to_node,
  input  logic signed [31:0] value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_index,
  output logic signed [31:0] out_value,
  output logic [3:0]         best_index,
  output logic               end_of_vector,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sllam_pkg::*;

  localparam int unsigned AW = $clog2(LAYERS*NODES*NODES);
  localparam int unsigned NW = $clog2(NODES);

  logic [CfgW-1:0] active_layers;
  logic            q_valid;
  logic            q_pop;
  op_t             q_op;
  logic [AW-1:0]   q_addr;
  logic [NW-1:0]   q_vidx;
  logic [31:0]     q_value;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(active_layers) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_layers <= CfgW'(4);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      active_layers <= pwdata[CfgW-1:0];
    end
  end

  sllam_front #(
    .NODES (NODES),
    .LAYERS(LAYERS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .layer_index(layer_index),
    .from_node  (from_node),
    .to_node    (to_node),
    .value      (value),
    .last       (last),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_op       (q_op),
    .q_addr     (q_addr),
    .q_vidx     (q_vidx),
    .q_value    (q_value)
  );

  sllam_back #(
    .NODES (NODES),
    .LAYERS(LAYERS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_op         (q_op),
    .q_addr       (q_addr),
    .q_vidx       (q_vidx),
    .q_value      (q_value),
    .active_layers(active_layers),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_index    (out_index),
    .out_value    (out_value),
    .best_index   (best_index),
    .end_of_vector(end_of_vector)
  );

endmodule

[hdl/sllam_ram.sv]
// ----------------------------------------------------------------------------
// sllam_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sllam_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/sllam_front.sv]
// ----------------------------------------------------------------------------
// sllam_front
// Accepts input beats, decodes them into operations and queues them.
// ----------------------------------------------------------------------------
module sllam_front #(
  parameter int unsigned NODES  = 16,
  parameter int unsigned LAYERS = 4
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    func,
  input  logic [1:0]                              layer_index,
  input  logic [3:0]                              from_node,
  input  logic [3:0]                              to_node,
  input  logic signed [31:0]                      value,
  input  logic                                    last,
  output logic                                    q_valid,
  input  logic                                    q_pop,
  output sllam_pkg::op_t                          q_op,
  output logic [$clog2(LAYERS*NODES*NODES)-1:0]   q_addr,
  output logic [$clog2(NODES)-1:0]                q_vidx,
  output logic [31:0]                             q_value
);
  import sllam_pkg::*;

  localparam int unsigned AW = $clog2(LAYERS*NODES*NODES);
  localparam int unsigned NW = $clog2(NODES);

  op_t              op_d;
  logic [31:0]      addr_full;
  logic             push;
  op_t              f_op    [2];
  logic [AW-1:0]    f_addr  [2];
  logic [NW-1:0]    f_vidx  [2];
  logic [31:0]      f_value [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  always_comb begin
    addr_full = 32'(layer_index) * 32'(NODES*NODES) + 32'(to_node) * 32'(NODES)
              + 32'(from_node);
    if (!func) begin
      if (32'(layer_index) < LAYERS && 32'(from_node) < NODES && 32'(to_node) < NODES) begin
        op_d = OP_WEIGHT;
      end else begin
        op_d = OP_NOP;
      end
    end else if (32'(from_node) < NODES) begin
      op_d = last ? OP_LOAD_RUN : OP_LOAD;
    end else begin
      op_d = last ? OP_RUN : OP_NOP;
    end
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_op     = f_op[rd_ptr];
  assign q_addr   = f_addr[rd_ptr];
  assign q_vidx   = f_vidx[rd_ptr];
  assign q_value  = f_value[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      f_op[wr_ptr]    <= op_d;
      f_addr[wr_ptr]  <= addr_full[AW-1:0];
      f_vidx[wr_ptr]  <= NW'(from_node);
      f_value[wr_ptr] <= value;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[hdl/sllam_back.sv]
// ----------------------------------------------------------------------------
// sllam_back
// Executes queued operations: weight writes, vector loads, the layer
// multiply-accumulate runs and the emission of the result vector.
// ----------------------------------------------------------------------------
module sllam_back #(
  parameter int unsigned NODES  = 16,
  parameter int unsigned LAYERS = 4
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  output logic                                    q_pop,
  input  sllam_pkg::op_t                          q_op,
  input  logic [$clog2(LAYERS*NODES*NODES)-1:0]   q_addr,
  input  logic [$clog2(NODES)-1:0]                q_vidx,
  input  logic [31:0]                             q_value,
  input  logic [2:0]                              active_layers,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [3:0]                              out_index,
  output logic signed [31:0]                      out_value,
  output logic [3:0]                              best_index,
  output logic                                    end_of_vector
);
  import sllam_pkg::*;

  localparam int unsigned AW = $clog2(LAYERS*NODES*NODES);
  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned LW = $clog2(LAYERS+1);
  localparam logic [NW-1:0] LastNode = NW'(NODES-1);

  state_t            state;
  state_t            state_next;
  logic [LW-1:0]     n_eff;
  logic [LW-1:0]     lay;
  logic [NW-1:0]     row;
  logic [NW-1:0]     col;
  logic [NW-1:0]     k;
  logic [AW-1:0]     run_addr;
  logic [AW-1:0]     ram_addr;
  logic              ram_we;
  logic [31:0]       ram_rdata;
  logic [31:0]       in_vec [NODES];
  logic [31:0]       wbuf   [2][NODES];
  logic [31:0]       src_val;
  logic              s1_valid, s1_first, s1_lastc, s1_dst;
  logic [NW-1:0]     s1_row;
  logic [31:0]       s1_vec;
  logic              s2_valid, s2_first, s2_lastc, s2_dst;
  logic [NW-1:0]     s2_row;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] acc_sum;
  logic              start;
  logic              issue_end;
  logic              out_load;
  logic [31:0]       emit_val;
  logic              emit_better;
  logic [NW-1:0]     best_new;
  logic [31:0]       best_val;
  logic [NW-1:0]     best_idx;

  assign n_eff = (32'(active_layers) > LAYERS) ? LW'(LAYERS) : LW'(active_layers);

  assign q_pop     = q_valid && (state == ST_IDLE);
  assign start     = q_pop && (q_op == OP_LOAD_RUN || q_op == OP_RUN);
  assign issue_end = (state == ST_RUN) && (col == LastNode) && (row == LastNode);
  assign out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign ram_we    = q_pop && (q_op == OP_WEIGHT);
  assign ram_addr  = (state == ST_IDLE) ? q_addr : run_addr;
  assign src_val   = (lay == '0) ? in_vec[col] : wbuf[!lay[0]][col];
  assign acc_sum   = s2_first ? prod : acc + prod;
  assign emit_val  = (n_eff == '0) ? in_vec[k] : wbuf[!n_eff[0]][k];
  assign emit_better = (k == '0) || ($signed(emit_val) > $signed(best_val));
  assign best_new  = emit_better ? k : best_idx;

  sllam_ram #(
    .WIDTH(32),
    .DEPTH(LAYERS*NODES*NODES)
  ) u_wram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(q_value),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (n_eff == '0) ? ST_EMIT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = (lay == n_eff) ? ST_EMIT : ST_RUN;
        end
      end
      ST_EMIT: begin
        if (out_load && k == LastNode) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_op == OP_LOAD || q_op == OP_LOAD_RUN)) begin
      in_vec[q_vidx] <= q_value;
    end
    if (start) begin
      lay      <= '0;
      row      <= '0;
      col      <= '0;
      k        <= '0;
      run_addr <= '0;
    end else if (state == ST_RUN) begin
      run_addr <= run_addr + 1'b1;
      col      <= (col == LastNode) ? '0 : col + 1'b1;
      if (col == LastNode) begin
        row <= (row == LastNode) ? '0 : row + 1'b1;
        if (row == LastNode) begin
          lay <= lay + 1'b1;
        end
      end
    end else if (out_load) begin
      k <= k + 1'b1;
    end
    s1_first <= (col == '0);
    s1_lastc <= (col == LastNode);
    s1_row   <= row;
    s1_dst   <= lay[0];
    s1_vec   <= src_val;
    prod     <= $signed(ram_rdata) * $signed(s1_vec);
    s2_first <= s1_first;
    s2_lastc <= s1_lastc;
    s2_row   <= s1_row;
    s2_dst   <= s1_dst;
    if (s2_valid) begin
      acc <= acc_sum;
      if (s2_lastc) begin
        wbuf[s2_dst][s2_row] <= sat_q16(acc_sum);
      end
    end
    if (out_load) begin
      out_index     <= 4'(k);
      out_value     <= emit_val;
      best_index    <= (k == LastNode) ? 4'(best_new) : 4'd0;
      end_of_vector <= (k == LastNode);
      best_val      <= emit_better ? emit_val : best_val;
      best_idx      <= best_new;
    end
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
      s2_valid <= s1_valid;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/sllam_checker.sv]
// ----------------------------------------------------------------------------
// sllam_checker
// Port-level checks on the result channel of the top level.
// ----------------------------------------------------------------------------
module sllam_checker #(
  parameter int unsigned NODES = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_index,
  input logic [31:0] out_value,
  input logic [3:0]  best_index,
  input logic        end_of_vector
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_index))
    else $error("Stalled result beat changed.");

  a_best_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_vector |-> best_index == 4'd0)
    else $error("Argmax shown on a beat that is not the last.");

  a_end_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_vector |-> out_index == 4'(NODES-1))
    else $error("End of vector on the wrong element.");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind stacked_linear_layers_argmax_top sllam_checker #(.NODES(NODES)) u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_index    (out_index),
  .out_value    (out_value),
  .best_index   (best_index),
  .end_of_vector(end_of_vector)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for stacked_linear_layers_argmax_top
// Writes weights and loads input vectors through random handshake gaps. It
// switches the layer count over the configuration port and checks every
// result beat against a fixed-point model of the layer chain and the argmax.
// ----------------------------------------------------------------------------
module testbench;
  import sllam_pkg::*;

  localparam int unsigned NumNodes  = 16;
  localparam int unsigned NumLayers = 4;
  localparam logic [2:0]  AddrActiveLayers = 3'd0;
  localparam logic        FuncWeight = 1'b0;
  localparam logic        FuncLoad   = 1'b1;
  localparam int          StallLimit = 20000;

  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] val;
    logic [3:0]  best;
    logic        eov;
  } vec_elem_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              func = 1'b0;
  logic [1:0]        layer_index = '0;
  logic [3:0]        from_node = '0;
  logic [3:0]        to_node = '0;
  logic signed [31:0] value = '0;
  logic              last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        out_index;
  logic signed [31:0] out_value;
  logic [3:0]        best_index;
  logic              end_of_vector;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic [31:0]  weights [NumLayers][NumNodes][NumNodes];
  logic [31:0]  in_vec [NumNodes];
  logic [CfgW-1:0] layer_count = CfgW'(4);
  vec_elem_t    layer_out_q [$];
  int           mismatches = 0;
  int           vectors_run = 0;
  int           beats_sent = 0;
  int           beats_checked = 0;
  int           idle_cycles = 0;
  bit           no_gaps = 1'b0;

  stacked_linear_layers_argmax_top uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= no_gaps ? 1'b0 : ($urandom_range(99) < 11);
  end

  function automatic logic [31:0] sat_shift(input longint acc);
    longint sh;
    sh = acc >>> 16;
    if (sh > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (sh < -64'sd2147483648) return 32'h8000_0000;
    return sh[31:0];
  endfunction

  function automatic void propagate_vector();
    logic signed [31:0] cur [NumNodes];
    logic signed [31:0] nxt [NumNodes];
    longint acc;
    int n, best;
    vec_elem_t e;
    n = (layer_count > NumLayers) ? NumLayers : layer_count;
    foreach (cur[k]) cur[k] = in_vec[k];
    for (int l = 0; l < n; l++) begin
      for (int r = 0; r < NumNodes; r++) begin
        acc = 0;
        for (int c = 0; c < NumNodes; c++) begin
          acc += longint'($signed(weights[l][r][c])) * longint'(cur[c]);
        end
        nxt[r] = sat_shift(acc);
      end
      cur = nxt;
    end
    best = 0;
    for (int k = 1; k < NumNodes; k++) begin
      if (cur[k] > cur[best]) best = k;
    end
    for (int k = 0; k < NumNodes; k++) begin
      e.idx  = k[3:0];
      e.val  = cur[k];
      e.best = (k == NumNodes - 1) ? best[3:0] : 4'd0;
      e.eov  = (k == NumNodes - 1);
      layer_out_q.push_back(e);
    end
    vectors_run++;
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return 32'($signed(18'($urandom())));
    endcase
  endfunction

  task automatic send_beat(input logic f, input logic [1:0] l, input logic [3:0] fr,
                           input logic [3:0] t, input logic [31:0] v, input logic lst);
    if (!no_gaps) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    func        <= f;
    layer_index <= l;
    from_node   <= fr;
    to_node     <= t;
    value       <= v;
    last        <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (f == FuncWeight) begin
      weights[l][t][fr] = v;
    end else begin
      in_vec[fr] = v;
      if (lst) propagate_vector();
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (layer_out_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_layer_count(input logic [CfgW-1:0] n);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AddrActiveLayers;
    pwdata  <= 32'(n);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    layer_count = n;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    vec_elem_t e;
    if (!rst && out_valid && !out_stall) begin
      beats_checked++;
      if (layer_out_q.size() == 0) begin
        $display("%0t: unexpected beat idx=%0d val=%h", $time, out_index, out_value);
        mismatches++;
      end else begin
        e = layer_out_q.pop_front();
        if (out_index !== e.idx) begin
          $display("%0t: out_index exp %0d got %0d", $time, e.idx, out_index);
          mismatches++;
        end
        if (out_value !== e.val) begin
          $display("%0t: out_value idx %0d exp %h got %h", $time, e.idx, e.val, out_value);
          mismatches++;
        end
        if (best_index !== e.best) begin
          $display("%0t: best_index exp %0d got %0d", $time, e.best, best_index);
          mismatches++;
        end
        if (end_of_vector !== e.eov) begin
          $display("%0t: end_of_vector exp %0b got %0b", $time, e.eov, end_of_vector);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_fill_weights();
    for (int l = 0; l < NumLayers; l++)
      for (int t = 0; t < NumNodes; t++)
        for (int f = 0; f < NumNodes; f++)
          send_beat(FuncWeight, 2'(l), 4'(f), 4'(t), 32'($signed(18'($urandom()))),
                    1'($urandom_range(1)));
    for (int k = 0; k < NumNodes; k++)
      send_beat(FuncLoad, 2'($urandom()), 4'(k), 4'($urandom()), pick_q16(),
                k == NumNodes - 1);
    settle();
  endtask

  task automatic test_extremes();
    set_layer_count(CfgW'(1));
    for (int k = 0; k < NumNodes; k++)
      send_beat(FuncLoad, 2'd0, 4'(k), 4'd0, 32'd0, k == NumNodes - 1);
    send_beat(FuncWeight, 2'd0, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b1);
    send_beat(FuncWeight, 2'd0, 4'd0, 4'd1, 32'h8000_0000, 1'b0);
    send_beat(FuncLoad, 2'd3, 4'd0, 4'd15, 32'h7FFF_FFFF, 1'b1);
    send_beat(FuncLoad, 2'd0, 4'd0, 4'd0, 32'h8000_0000, 1'b1);
    settle();
    set_layer_count(CfgW'(0));
    send_beat(FuncLoad, 2'd1, 4'd15, 4'd3, 32'h7FFF_FFFF, 1'b1);
    settle();
    set_layer_count(CfgW'(7));
    send_beat(FuncLoad, 2'd2, 4'd7, 4'd9, 32'h0001_0000, 1'b1);
    settle();
  endtask

  task automatic test_random_runs(input int rounds);
    logic [CfgW-1:0] counts [6] = '{1, 2, 3, 4, 0, 7};
    int nw, nl;
    for (int r = 0; r < rounds; r++) begin
      if (r % 10 == 0) begin
        settle();
        set_layer_count(counts[$urandom_range(5)]);
      end
      no_gaps = (r >= 20 && r < 30);
      nw = $urandom_range(4);
      nl = $urandom_range(1, 4);
      for (int i = 0; i < nw; i++)
        send_beat(FuncWeight, 2'($urandom()), 4'($urandom()), 4'($urandom()), pick_q16(),
                  1'($urandom_range(1)));
      for (int i = 0; i < nl; i++)
        send_beat(FuncLoad, 2'($urandom()), 4'($urandom()), 4'($urandom()), pick_q16(),
                  i == nl - 1);
    end
    no_gaps = 1'b0;
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_weights();
    test_extremes();
    test_random_runs(70);
    repeat (100) @(posedge clk);
    $display("Ran %0d vectors from %0d input beats; checked %0d result beats.",
             vectors_run, beats_sent, beats_checked);
    if (mismatches == 0 && layer_out_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
